[src/vsa_pkg.sv]
// Voice slot allocator package: request/response structs, slot entry layout,
// operation and result codes, field widths. No dependencies.
package vsa_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int SOUND_ID_BITS = 10;
    localparam int ENTITY_BITS   = 10;
    localparam int CHAN_BITS     = 4;
    localparam int OP_BITS       = 3;
    localparam int SLOT_BITS     = 5;
    localparam int HOW_BITS      = 2;

    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    // register word index (paddr above the byte offset)
    localparam logic REG_ENABLE_3D = 1'b0;

    localparam logic [OP_BITS-1:0] OP_ACQUIRE     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_RELEASE_ALL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_FIND        = 3'd3;
    localparam logic [OP_BITS-1:0] OP_NEXT_USED   = 3'd4;

    localparam logic [HOW_BITS-1:0] HOW_MATCH  = 2'd0;
    localparam logic [HOW_BITS-1:0] HOW_FREE   = 2'd1;
    localparam logic [HOW_BITS-1:0] HOW_STOLEN = 2'd2;
    localparam logic [HOW_BITS-1:0] HOW_NONE   = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]       op;
        logic [SOUND_ID_BITS-1:0] sound_id;
        logic [ENTITY_BITS-1:0]   entity;
        logic [CHAN_BITS-1:0]     ent_channel;
        logic                     want_3d;
        logic [SLOT_BITS-1:0]     slot_in;
        logic                     from_start;
    } vsa_req_t;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] slot_out;
        logic                 is_3d;
        logic [HOW_BITS-1:0]  how;
    } vsa_rsp_t;

    // tags held in RAM; the valid mark lives in flops
    typedef struct packed {
        logic                     kind_3d;
        logic [SOUND_ID_BITS-1:0] sound;
        logic [ENTITY_BITS-1:0]   entity;
        logic [CHAN_BITS-1:0]     chan;
    } slot_entry_t;

endpackage

[src/vsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/voice_slot_allocator_top.sv]
// Voice slot allocator top level: request sequencer, slot scan, APB register.
// Depends on vsa_pkg and vsa_ram.
//
// Acquire, find-by-sound and next-used requests scan every slot through the
// single read port of the tag RAM, one entry per cycle: the reads, the
// registered RAM read data, a decide/write-back step and the output load
// follow in that order. Release, release-all and unused codes do not read
// the RAM; release and release-all clear valid flops, and all three go
// straight to the output load. One request is in flight at a time; a new
// request is taken once the previous result has gone into the output
// register, and a stalled result holds the next request back from the
// output register for as long as it waits. The only write to the RAM happens
// after the scan, so reads and writes never touch the same entry in
// overlapping cycles.
module voice_slot_allocator_top #(
    parameter int NUM_SLOTS = vsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  vsa_pkg::vsa_req_t               s_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output vsa_pkg::vsa_rsp_t               m_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vsa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vsa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [vsa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import vsa_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = IW + 1;
    localparam int SW = (CW > SLOT_BITS + 1) ? CW : SLOT_BITS + 1;
    localparam int EW = $bits(slot_entry_t);
    localparam logic [CW-1:0] CNT_END   = CW'(NUM_SLOTS);
    localparam logic [IW-1:0] IDX_LAST  = IW'(NUM_SLOTS - 1);
    localparam logic [31:0]   NUM_SLOTS_U = 32'(NUM_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // control
    logic [1:0]           state_reg, state_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic                 enable_3d_reg, enable_3d_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic                 hit_reg, hit_next;
    logic                 free_hit_reg, free_hit_next;
    logic                 steal_hit_reg, steal_hit_next;
    logic                 m_valid_reg, m_valid_next;

    // payload
    vsa_req_t             req_reg, req_next;
    logic [SW-1:0]        start_reg, start_next;
    logic [IW-1:0]        chk_idx_reg, chk_idx_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 hit_kind_reg, hit_kind_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic [IW-1:0]        steal_idx_reg, steal_idx_next;
    vsa_rsp_t             res_reg, res_next;
    vsa_rsp_t             m_rsp_reg, m_rsp_next;

    // RAM port
    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    slot_entry_t          entry, new_entry;
    logic                 cur_v, tag_eq, hit_cond, free_cond, steal_cond;
    logic                 cfg_wr;

    vsa_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready
                   & (paddr[CFG_ADDR_W-1] == REG_ENABLE_3D);
    assign prdata  = (paddr[CFG_ADDR_W-1] == REG_ENABLE_3D)
                   ? {{(CFG_DATA_W-1){1'b0}}, enable_3d_reg} : '0;

    // per-entry compare on the registered RAM output
    assign entry      = slot_entry_t'(ram_rdata);
    assign cur_v      = valid_reg[chk_idx_reg];
    assign tag_eq     = (entry.entity == req_reg.entity) && (entry.chan == req_reg.ent_channel);
    assign free_cond  = !cur_v;
    assign steal_cond = cur_v && (req_reg.ent_channel != '0) && tag_eq;

    always_comb begin
        unique case (req_reg.op)
            OP_ACQUIRE: begin
                hit_cond = cur_v && (req_reg.sound_id != '0)
                         && (entry.sound == req_reg.sound_id) && tag_eq;
            end
            OP_FIND: begin
                hit_cond = cur_v && (req_reg.sound_id != '0)
                         && (entry.sound == req_reg.sound_id);
            end
            OP_NEXT_USED: begin
                hit_cond = cur_v && (SW'(chk_idx_reg) >= start_reg);
            end
            default: begin
                hit_cond = 1'b0;
            end
        endcase
    end

    assign new_entry.kind_3d = enable_3d_reg & req_reg.want_3d;
    assign new_entry.sound   = req_reg.sound_id;
    assign new_entry.entity  = req_reg.entity;
    assign new_entry.chan    = req_reg.ent_channel;

    always_comb begin
        logic [IW-1:0] pick_idx;
        logic          do_write;

        pick_idx       = free_idx_reg;
        do_write       = 1'b0;

        state_next     = state_reg;
        valid_next     = valid_reg;
        enable_3d_next = cfg_wr ? pwdata[0] : enable_3d_reg;
        rd_cnt_next    = rd_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_kind_next  = hit_kind_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        steal_hit_next = steal_hit_reg;
        steal_idx_next = steal_idx_reg;
        req_next       = req_reg;
        start_next     = start_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_rsp_next     = m_rsp_reg;

        ram_re         = 1'b0;
        ram_raddr      = rd_cnt_reg[IW-1:0];
        ram_we         = 1'b0;
        ram_waddr      = pick_idx;
        ram_wdata      = new_entry;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next       = s_req;
                    start_next     = s_req.from_start ? '0 : SW'(s_req.slot_in) + SW'(1);
                    rd_cnt_next    = '0;
                    hit_next       = 1'b0;
                    free_hit_next  = 1'b0;
                    steal_hit_next = 1'b0;
                    res_next       = '{found: 1'b0, slot_out: '0, is_3d: 1'b0, how: HOW_NONE};
                    unique case (s_req.op)
                        OP_ACQUIRE, OP_FIND, OP_NEXT_USED: begin
                            state_next = ST_SCAN;
                        end
                        OP_RELEASE: begin
                            if (32'(s_req.slot_in) < NUM_SLOTS_U) begin
                                valid_next[IW'(s_req.slot_in)] = 1'b0;
                            end
                            state_next = ST_OUT;
                        end
                        OP_RELEASE_ALL: begin
                            valid_next = '0;
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_cnt_reg != CNT_END) begin
                    ram_re       = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_cnt_reg[IW-1:0];
                end
                if (chk_vld_reg) begin
                    if (hit_cond && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_kind_next = entry.kind_3d;
                    end
                    if (free_cond && !free_hit_reg) begin
                        free_hit_next = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (steal_cond && !steal_hit_reg) begin
                        steal_hit_next = 1'b1;
                        steal_idx_next = chk_idx_reg;
                    end
                    if (chk_idx_reg == IDX_LAST) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (req_reg.op == OP_ACQUIRE) begin
                    priority if (hit_reg) begin
                        res_next = '{found: 1'b1, slot_out: SLOT_BITS'(hit_idx_reg),
                                     is_3d: hit_kind_reg, how: HOW_MATCH};
                    end else if (free_hit_reg) begin
                        pick_idx = free_idx_reg;
                        do_write = 1'b1;
                        res_next = '{found: 1'b1, slot_out: SLOT_BITS'(free_idx_reg),
                                     is_3d: new_entry.kind_3d, how: HOW_FREE};
                    end else if (steal_hit_reg) begin
                        pick_idx = steal_idx_reg;
                        do_write = 1'b1;
                        res_next = '{found: 1'b1, slot_out: SLOT_BITS'(steal_idx_reg),
                                     is_3d: new_entry.kind_3d, how: HOW_STOLEN};
                    end else begin
                        res_next = '{found: 1'b0, slot_out: '0, is_3d: 1'b0, how: HOW_NONE};
                    end
                end else if (hit_reg) begin
                    res_next = '{found: 1'b1, slot_out: SLOT_BITS'(hit_idx_reg),
                                 is_3d: hit_kind_reg, how: HOW_NONE};
                end
                if (do_write) begin
                    ram_we               = 1'b1;
                    ram_waddr            = pick_idx;
                    valid_next[pick_idx] = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            enable_3d_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_hit_reg  <= 1'b0;
            steal_hit_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            enable_3d_reg <= enable_3d_next;
            rd_cnt_reg    <= rd_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            free_hit_reg  <= free_hit_next;
            steal_hit_reg <= steal_hit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        start_reg     <= start_next;
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_kind_reg  <= hit_kind_next;
        free_idx_reg  <= free_idx_next;
        steal_idx_reg <= steal_idx_next;
        res_reg       <= res_next;
        m_rsp_reg     <= m_rsp_next;
    end

endmodule

[src/vsa_checker.sv]
// Port-level checker for the voice slot allocator, bound to the top level.
// Depends on vsa_pkg and voice_slot_allocator_top.
module vsa_port_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input vsa_pkg::vsa_req_t s_req,
    input logic              m_valid,
    input logic              m_ready,
    input vsa_pkg::vsa_rsp_t m_rsp,
    input logic              pready
);

    import vsa_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("result changed while stalled");

    // one request in flight: ready drops after an accepted request
    a_one_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    // no slot reported means zero slot and kind
    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.found |-> (m_rsp.slot_out == '0) && !m_rsp.is_3d)
        else $error("stray slot fields without a found slot");

    // match, free and stolen results always carry a slot
    a_how_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.how != HOW_NONE) |-> m_rsp.found)
        else $error("acquire outcome without a slot");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind voice_slot_allocator_top vsa_port_checker u_vsa_checker (.*);
